// ----- hdl/reuse_time_histogram_macros.svh -----
// Assertion macros for the reuse-time histogram block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef REUSE_TIME_HISTOGRAM_MACROS_SVH
`define REUSE_TIME_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
`define RTH_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rth assertion failed");
`define RTH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rth assertion failed");
`else
`define RTH_ASSERT_IMPL(name, ante, cons)
`define RTH_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- hdl/rth_pkg.sv -----
// Shared types, constants and helpers for the reuse-time histogram.
// No dependencies.
`timescale 1ns / 1ps
package rth_pkg;

    localparam int BUCKET_W = 13;
    localparam int OFFSET_W = 22;
    localparam int COUNT_W  = 32;
    localparam int TIME_W   = 32;
    // reuse time plus band bias fits in 33 bits
    localparam int T_W      = 33;
    localparam int GRP_W    = 8;
    localparam int NGRP     = 5;
    localparam int MSB_W    = 6;
    // clear sweep address covers the largest store
    localparam int CLR_AW   = 24;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PW     = 2;
    localparam int Q_CW     = 3;

    typedef enum logic [3:0] {
        K_READ  = 4'b0001,
        K_HIT   = 4'b0010,
        K_FIRST = 4'b0100,
        K_ZERO  = 4'b1000
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic                 ovf;
        logic [BUCKET_W-1:0]  bucket;
    } rth_tag_t;

    typedef struct packed {
        logic               busy;
        logic [CLR_AW-1:0]  addr;
    } rth_clr_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ----- hdl/rth_trace_if.sv -----
// Input channel: access or read item with valid/ready handshake.
// Depends on rth_pkg.
`timescale 1ns / 1ps
interface rth_trace_if;
    import rth_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [BUCKET_W-1:0]  bucket_sel;
    modport source (output valid, cmd, byte_offset, bucket_sel, input ready);
    modport sink (input valid, cmd, byte_offset, bucket_sel, output ready);
endinterface

// ----- hdl/rth_result_if.sv -----
// Output channel: one result per item with valid/ready handshake.
// Depends on rth_pkg.
`timescale 1ns / 1ps
interface rth_result_if;
    import rth_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 first_touch;
    logic [BUCKET_W-1:0]  bucket;
    logic [COUNT_W-1:0]   count;
    logic                 overflow;
    modport source (output valid, first_touch, bucket, count, overflow, input ready);
    modport sink (input valid, first_touch, bucket, count, overflow, output ready);
endinterface

// ----- hdl/rth_front.sv -----
// Front end: accepts items, tracks access time per line, maps reuse time
// to a bucket. Depends on rth_pkg and rth_trace_if.
`timescale 1ns / 1ps
module rth_front #(
    parameter int LINE_ADDR_BITS   = 16,
    parameter int HIST_DEPTH       = 8192,
    parameter int BUCKETS_PER_BAND = 256,
    parameter int LINE_SHIFT       = 6,
    localparam int HIST_AW         = $clog2(HIST_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    rth_trace_if.sink          trace,
    input  logic               q_ready,
    output logic               q_push,
    output rth_pkg::rth_tag_t  q_tag,
    output logic [HIST_AW-1:0] q_haddr,
    output rth_pkg::rth_clr_t  clr,
    output logic               ovf_flag
);
    import rth_pkg::*;

    localparam int TABLE_N  = 1 << LINE_ADDR_BITS;
    localparam int CLR_N    = (TABLE_N > HIST_DEPTH) ? TABLE_N : HIST_DEPTH;
    localparam int LOG_B    = $clog2(BUCKETS_PER_BAND);
    localparam int IDX_W    = MSB_W + LOG_B + 1;

    logic [TIME_W-1:0]  cnt_reg;
    logic               ovf_reg;
    logic               clr_busy_reg;
    logic [CLR_AW-1:0]  clr_addr_reg;

    logic                       accept;
    logic                       adv;
    logic                       is_acc;
    logic                       cnt_max;
    logic                       sel_ok;
    logic [LINE_ADDR_BITS-1:0]  line;
    logic [TIME_W-1:0]          new_time;
    kind_t                      kind0;

    logic [TIME_W-1:0] seen_mem [TABLE_N];
    logic [TIME_W-1:0] prev_q;

    // stage registers
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    rth_tag_t           s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;
    logic [HIST_AW-1:0] s1_haddr_reg, s2_haddr_reg, s3_haddr_reg, s4_haddr_reg, s5_haddr_reg;
    logic [TIME_W-1:0]  s1_time_reg;
    logic [T_W-1:0]     s2_t_reg, s3_t_reg, s4_t_reg;
    logic [NGRP-1:0]    s3_nz_reg;
    logic [2:0]         s3_pos_reg [NGRP];
    logic [MSB_W-1:0]   s4_k_reg;

    logic [NGRP*GRP_W-1:0] t_ext;
    logic [NGRP-1:0]       nz_next;
    logic [2:0]            pos_next [NGRP];
    logic [MSB_W-1:0]      msb_next;
    logic [T_W-1:0]        shifted;
    logic [IDX_W-1:0]      idx;
    logic [HIST_AW-1:0]    idx_sat;
    rth_tag_t              s2_tag_next;
    rth_tag_t              s5_tag_next;
    logic [HIST_AW-1:0]    s5_haddr_next;

    assign adv         = q_ready;
    assign trace.ready = adv && !clr_busy_reg;
    assign accept      = trace.valid && trace.ready;
    assign is_acc      = (trace.cmd == 1'b0);
    assign cnt_max     = (cnt_reg == '1);
    assign sel_ok      = 32'(trace.bucket_sel) < 32'(HIST_DEPTH);
    assign line        = LINE_ADDR_BITS'(trace.byte_offset >> LINE_SHIFT);
    assign new_time    = cnt_reg + TIME_W'(1);

    // classify the incoming item
    always_comb
    begin
        if (!is_acc)
        begin
            kind0 = sel_ok ? K_READ : K_ZERO;
        end
        else if (cnt_max)
        begin
            kind0 = K_ZERO;
        end
        else
        begin
            kind0 = K_HIT;
        end
    end

    // last access time per line, old value read on the same edge as the update
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            seen_mem[LINE_ADDR_BITS'(clr_addr_reg)] <= '0;
        end
        else if (accept && is_acc && !cnt_max)
        begin
            seen_mem[line] <= new_time;
        end
        if (accept)
        begin
            prev_q <= seen_mem[line];
        end
    end

    // counter, overflow, clear sweep and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == CLR_AW'(CLR_N - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + CLR_AW'(1);
                end
            end
            if (accept && is_acc)
            begin
                if (cnt_max)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= new_time;
                end
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // first touch detection
    always_comb
    begin
        s2_tag_next = s1_tag_reg;
        if (s1_tag_reg.kind == K_HIT && prev_q == '0)
        begin
            s2_tag_next.kind = K_FIRST;
        end
    end

    // find highest set bit inside each byte of the biased reuse time
    always_comb
    begin
        t_ext = (NGRP*GRP_W)'(s2_t_reg);
        for (int g = 0; g < NGRP; g++)
        begin
            nz_next[g]  = |t_ext[g*GRP_W +: GRP_W];
            pos_next[g] = '0;
            for (int b = 0; b < GRP_W; b++)
            begin
                if (t_ext[g*GRP_W + b])
                begin
                    pos_next[g] = 3'(b);
                end
            end
        end
    end

    // pick the highest nonzero byte
    always_comb
    begin
        msb_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (s3_nz_reg[g])
            begin
                msb_next = {3'(g), s3_pos_reg[g]};
            end
        end
    end

    // band index and offset inside the band, clamped to the histogram
    always_comb
    begin
        shifted = s4_t_reg >> s4_k_reg;
        idx     = IDX_W'({s4_k_reg, shifted[LOG_B-1:0]}) + IDX_W'(1);
        if (32'(idx) >= 32'(HIST_DEPTH))
        begin
            idx_sat = HIST_AW'(HIST_DEPTH - 1);
        end
        else
        begin
            idx_sat = HIST_AW'(idx);
        end
        s5_tag_next   = s4_tag_reg;
        s5_haddr_next = s4_haddr_reg;
        if (s4_tag_reg.kind == K_HIT)
        begin
            s5_tag_next.bucket = BUCKET_W'(idx_sat);
            s5_haddr_next      = idx_sat;
        end
    end

    // advance payload through the stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg.kind   <= kind0;
            s1_tag_reg.ovf    <= ovf_reg | (is_acc & cnt_max);
            s1_tag_reg.bucket <= is_acc ? '0 : trace.bucket_sel;
            s1_haddr_reg      <= HIST_AW'(trace.bucket_sel);
            s1_time_reg       <= new_time;

            s2_tag_reg   <= s2_tag_next;
            s2_haddr_reg <= s1_haddr_reg;
            s2_t_reg     <= T_W'(s1_time_reg - prev_q) + T_W'(BUCKETS_PER_BAND - 1);

            s3_tag_reg   <= s2_tag_reg;
            s3_haddr_reg <= s2_haddr_reg;
            s3_t_reg     <= s2_t_reg;
            s3_nz_reg    <= nz_next;
            s3_pos_reg   <= pos_next;

            s4_tag_reg   <= s3_tag_reg;
            s4_haddr_reg <= s3_haddr_reg;
            s4_t_reg     <= s3_t_reg;
            s4_k_reg     <= msb_next - MSB_W'(LOG_B);

            s5_tag_reg   <= s5_tag_next;
            s5_haddr_reg <= s5_haddr_next;
        end
    end

    assign q_push   = s5_valid_reg && adv;
    assign q_tag    = s5_tag_reg;
    assign q_haddr  = s5_haddr_reg;
    assign clr.busy = clr_busy_reg;
    assign clr.addr = clr_addr_reg;
    assign ovf_flag = ovf_reg;

endmodule

// ----- hdl/rth_queue.sv -----
// Short FIFO between the front end and the histogram back end.
// Depends on rth_pkg.
`timescale 1ns / 1ps
module rth_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         room,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         avail,
    output logic [W-1:0] rdata
);
    import rth_pkg::*;

    logic [W-1:0]     mem [Q_DEPTH];
    logic [Q_PW-1:0]  wr_ptr_reg;
    logic [Q_PW-1:0]  rd_ptr_reg;
    logic [Q_CW-1:0]  cnt_reg;

    assign room  = (cnt_reg != Q_CW'(Q_DEPTH));
    assign avail = (cnt_reg != '0);
    assign rdata = mem[rd_ptr_reg];

    // store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + Q_CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - Q_CW'(1);
            end
        end
    end

endmodule

// ----- hdl/rth_back.sv -----
// Back end: histogram read-modify-write with forwarding, result register.
// Depends on rth_pkg and rth_result_if.
`timescale 1ns / 1ps
module rth_back #(
    parameter int HIST_DEPTH = 8192,
    localparam int HIST_AW   = $clog2(HIST_DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_avail,
    output logic               q_pop,
    input  rth_pkg::rth_tag_t  q_tag,
    input  logic [HIST_AW-1:0] q_haddr,
    input  rth_pkg::rth_clr_t  clr,
    rth_result_if.source       result
);
    import rth_pkg::*;

    logic [COUNT_W-1:0] hist_mem [HIST_DEPTH];
    logic [COUNT_W-1:0] hq_reg;

    logic               h1_valid_reg;
    rth_tag_t           h1_tag_reg;
    logic [HIST_AW-1:0] h1_haddr_reg;
    logic               h1_fwd_reg;
    logic [COUNT_W-1:0] h1_fwd_data_reg;

    logic                out_valid_reg;
    logic                out_first_reg;
    logic [BUCKET_W-1:0] out_bucket_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_ovf_reg;

    logic               adv;
    logic               h1_write;
    logic [COUNT_W-1:0] cur_val;
    logic [COUNT_W-1:0] new_val;

    assign adv      = !out_valid_reg || result.ready;
    assign q_pop    = adv && q_avail;
    assign h1_write = adv && h1_valid_reg && (h1_tag_reg.kind == K_HIT);
    assign cur_val  = h1_fwd_reg ? h1_fwd_data_reg : hq_reg;
    assign new_val  = sat_inc(cur_val);

    // histogram store: clear sweep, increment write-back, registered read
    always_ff @(posedge clk)
    begin
        if (clr.busy && (32'(clr.addr) < 32'(HIST_DEPTH)))
        begin
            hist_mem[HIST_AW'(clr.addr)] <= '0;
        end
        else if (h1_write)
        begin
            hist_mem[h1_haddr_reg] <= new_val;
        end
        if (q_pop)
        begin
            hq_reg <= hist_mem[q_haddr];
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            h1_valid_reg  <= q_avail;
            out_valid_reg <= h1_valid_reg;
        end
    end

    // forward the value written on the edge the next read is issued
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_tag_reg      <= q_tag;
            h1_haddr_reg    <= q_haddr;
            h1_fwd_reg      <= h1_write && (h1_haddr_reg == q_haddr);
            h1_fwd_data_reg <= new_val;

            out_first_reg  <= (h1_tag_reg.kind == K_FIRST);
            out_bucket_reg <= h1_tag_reg.bucket;
            out_ovf_reg    <= h1_tag_reg.ovf;
            unique case (h1_tag_reg.kind)
                K_HIT:   out_count_reg <= new_val;
                K_READ:  out_count_reg <= cur_val;
                default: out_count_reg <= '0;
            endcase
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.first_touch = out_first_reg;
    assign result.bucket      = out_bucket_reg;
    assign result.count       = out_count_reg;
    assign result.overflow    = out_ovf_reg;

endmodule

// ----- hdl/reuse_time_histogram.sv -----
// Reuse-time histogram top level: front end, queue, histogram back end.
// One item per cycle while the result side is ready and no clearing sweep runs.
// Throughput is set by the histogram read-modify-write with forwarding.
// After reset a clearing sweep over max(2**LINE_ADDR_BITS, HIST_DEPTH) addresses
// (65536 by default) zeroes both stores; input ready stays low until it ends.
// Depends on rth_pkg, rth_trace_if, rth_result_if, rth_front, rth_queue, rth_back.
`timescale 1ns / 1ps
`include "reuse_time_histogram_macros.svh"
module reuse_time_histogram #(
    parameter int LINE_ADDR_BITS   = 16,
    parameter int HIST_DEPTH       = 8192,
    parameter int BUCKETS_PER_BAND = 256,
    parameter int LINE_SHIFT       = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    rth_trace_if.sink    trace,
    rth_result_if.source result
);
    import rth_pkg::*;

    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int QW      = $bits(rth_tag_t) + HIST_AW;

    logic               q_push;
    logic               q_room;
    logic               q_pop;
    logic               q_avail;
    rth_tag_t           f_tag;
    logic [HIST_AW-1:0] f_haddr;
    rth_tag_t           b_tag;
    logic [HIST_AW-1:0] b_haddr;
    logic [QW-1:0]      q_rdata;
    rth_clr_t           clr;
    logic               ovf_flag;

    rth_front #(
        .LINE_ADDR_BITS   (LINE_ADDR_BITS),
        .HIST_DEPTH       (HIST_DEPTH),
        .BUCKETS_PER_BAND (BUCKETS_PER_BAND),
        .LINE_SHIFT       (LINE_SHIFT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .trace    (trace),
        .q_ready  (q_room),
        .q_push   (q_push),
        .q_tag    (f_tag),
        .q_haddr  (f_haddr),
        .clr      (clr),
        .ovf_flag (ovf_flag)
    );

    rth_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .room  (q_room),
        .wdata ({f_tag, f_haddr}),
        .pop   (q_pop),
        .avail (q_avail),
        .rdata (q_rdata)
    );

    assign {b_tag, b_haddr} = q_rdata;

    rth_back #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_pop   (q_pop),
        .q_tag   (b_tag),
        .q_haddr (b_haddr),
        .clr     (clr),
        .result  (result)
    );

    // no transfer while the stores are being cleared
    `RTH_ASSERT_IMPL(a_no_accept_in_clear, clr.busy, !(trace.valid && trace.ready))
    // overflow stays set until reset
    `RTH_ASSERT_NEXT(a_ovf_sticky, ovf_flag, ovf_flag)
    // a first touch reports no bucket and no count
    `RTH_ASSERT_IMPL(a_first_zero, result.valid && result.first_touch, result.count == 0 && result.bucket == 0)
    // the queue is never written while full
    `RTH_ASSERT_IMPL(a_queue_room, q_push, q_room)

endmodule

// ----- test/rth_checker.sv -----
// Checker for the reuse-time histogram: watches both channels, predicts results.
// Depends on rth_pkg, rth_trace_if, rth_result_if.
`timescale 1ns / 1ps
module rth_checker (
    input  logic      clk,
    input  logic      rst_n,
    rth_trace_if      trace,
    rth_result_if     result,
    output int        fail_count,
    output int        pending
);
    import rth_pkg::*;

    localparam int LINES     = 65536;
    localparam int HIST      = 8192;
    localparam int PER_BAND  = 256;
    localparam int SHIFT     = 6;
    localparam logic CMD_READ   = 1'b1;

    typedef struct packed {
        logic                first_touch;
        logic [BUCKET_W-1:0] bucket;
        logic [COUNT_W-1:0]  count;
        logic                overflow;
    } histo_result_t;

    logic [TIME_W-1:0]  now_time;
    logic [TIME_W-1:0]  seen_at [LINES];
    logic [COUNT_W-1:0] hist_count [HIST];
    logic               sat_flag;
    histo_result_t      expected_q[$];

    assign pending = expected_q.size();

    // map a reuse time to its log-linear bucket
    function automatic longint unsigned band_bucket(input longint unsigned v);
        longint unsigned loc, step, idx;
        loc = 0;
        step = 1;
        idx = 0;
        while (loc + step * PER_BAND < v)
        begin
            loc += step * PER_BAND;
            step <<= 1;
            idx += PER_BAND;
        end
        if (loc < v)
            idx += (v - loc + step - 1) / step;
        return idx;
    endfunction

    // advance the model by one accepted transfer
    function automatic histo_result_t predict_access(input logic cmd,
        input logic [OFFSET_W-1:0] off, input logic [BUCKET_W-1:0] sel);
        histo_result_t r;
        logic [15:0] line;
        logic [TIME_W-1:0] prev;
        longint unsigned b;
        r = '0;
        if (cmd == CMD_READ)
        begin
            r.bucket = sel;
            r.count = hist_count[sel];
        end
        else if (now_time == '1)
            sat_flag = 1'b1;
        else
        begin
            line = 16'(off >> SHIFT);
            now_time = now_time + 1;
            prev = seen_at[line];
            if (prev == '0)
                r.first_touch = 1'b1;
            else
            begin
                b = band_bucket(longint'(TIME_W'(now_time - prev)));
                if (b >= HIST)
                    b = HIST - 1;
                if (hist_count[b] != '1)
                    hist_count[b] = hist_count[b] + 1;
                r.bucket = BUCKET_W'(b);
                r.count = hist_count[b];
            end
            seen_at[line] = now_time;
        end
        r.overflow = sat_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
        input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        now_time = '0;
        sat_flag = 1'b0;
        fail_count = 0;
        foreach (seen_at[i]) seen_at[i] = '0;
        foreach (hist_count[i]) hist_count[i] = '0;
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        histo_result_t want;
        if (rst_n)
        begin
            if (trace.valid && trace.ready)
                expected_q.push_back(predict_access(trace.cmd, trace.byte_offset,
                    trace.bucket_sel));
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (result.first_touch !== want.first_touch)
                        report_mismatch("first_touch", result.first_touch, want.first_touch);
                    if (result.bucket !== want.bucket)
                        report_mismatch("bucket", result.bucket, want.bucket);
                    if (result.count !== want.count)
                        report_mismatch("count", result.count, want.count);
                    if (result.overflow !== want.overflow)
                        report_mismatch("overflow", result.overflow, want.overflow);
                end
            end
        end
    end
endmodule

// ----- test/tb_reuse_time_histogram.sv -----
// Testbench top for the reuse-time histogram: stimulus, clock, reset, verdict.
// Depends on rth_pkg, the channel interfaces, rth_checker and the block.
`timescale 1ns / 1ps
module tb_reuse_time_histogram;
    import rth_pkg::*;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam int   RANDOM_ITEMS = 1030;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   tail_phase;
    longint cycles;
    logic [OFFSET_W-1:0] hot_lines [16];

    rth_trace_if  trace ();
    rth_result_if result ();

    reuse_time_histogram dut (.clk(clk), .rst_n(rst_n), .trace(trace), .result(result));
    rth_checker checker_i (.clk(clk), .rst_n(rst_n), .trace(trace), .result(result),
        .fail_count(fail_count), .pending(pending));

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_reuse_time_histogram failed");
            $finish;
        end
    end

    // result side: random stall bursts until the tail
    initial
    begin
        int n;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!tail_phase && $urandom_range(0, 5) == 0)
            begin
                result.ready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n) @(negedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    // drive one transfer and hold until it is taken
    task automatic send_item(input logic cmd, input logic [OFFSET_W-1:0] off,
        input logic [BUCKET_W-1:0] sel);
        int n;
        if (!tail_phase && $urandom_range(0, 7) == 0)
        begin
            trace.valid <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(negedge clk);
        end
        trace.valid <= 1'b1;
        trace.cmd <= cmd;
        trace.byte_offset <= off;
        trace.bucket_sel <= sel;
        @(posedge clk);
        while (!trace.ready) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [OFFSET_W-1:0] off;
        int k;
        cycles = 0;
        tail_phase = 0;
        rst_n = 1'b0;
        trace.valid = 1'b0;
        trace.cmd = CMD_ACCESS;
        trace.byte_offset = '0;
        trace.bucket_sel = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: first touches, short and long reuse, reads at extremes
        send_item(CMD_ACCESS, '0, '1);
        send_item(CMD_ACCESS, '0, '0);
        send_item(CMD_ACCESS, 22'h3FFFFF, '0);
        send_item(CMD_ACCESS, 22'h3FFFC0, '0);
        send_item(CMD_ACCESS, 22'h00003F, '0);
        for (int i = 1; i <= 6; i++)
            send_item(CMD_ACCESS, OFFSET_W'(i * 64), '0);
        for (int i = 1; i <= 6; i++)
            send_item(CMD_ACCESS, OFFSET_W'(i * 64 + 5), '0);
        send_item(CMD_ACCESS, 22'h3FFFFF, '0);
        send_item(CMD_READ, '1, '0);
        send_item(CMD_READ, '0, 13'd1);
        send_item(CMD_READ, '0, 13'd7);
        send_item(CMD_READ, '0, '1);
        send_item(CMD_READ, 22'h2AAAAA, 13'h1555);

        // hold off until the block has drained
        trace.valid <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int i = 0; i < 16; i++)
            hot_lines[i] = OFFSET_W'($urandom);

        // random: mostly reuse of a hot set, some wide spread, some reads
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - 150)
                tail_phase = 1;
            k = $urandom_range(0, 9);
            if (k < 5)
                send_item(CMD_ACCESS, hot_lines[$urandom_range(0, 15)] ^ OFFSET_W'($urandom_range(0, 63)),
                    BUCKET_W'($urandom));
            else if (k < 7)
            begin
                off = OFFSET_W'($urandom);
                send_item(CMD_ACCESS, off, BUCKET_W'($urandom));
            end
            else if (k < 9)
                send_item(CMD_READ, OFFSET_W'($urandom), BUCKET_W'($urandom_range(0, 300)));
            else
                send_item(CMD_READ, OFFSET_W'($urandom), BUCKET_W'($urandom));
        end
        trace.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_reuse_time_histogram passed");
        else
            $display("tb_reuse_time_histogram failed");
        $finish;
    end
endmodule
